// ===== design/wfw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfw_pkg
// Shared widths, codes and types for the weighted FIFO with watermarks.
// ----------------------------------------------------------------------------
package wfw_pkg;

	localparam int WEIGHT_W  = 16;
	localparam int ACTION_W  = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 8;
	localparam int DIV_CNT_W = $clog2(WEIGHT_W + 1);

	localparam logic [WEIGHT_W-1:0] CAPACITY_RST = 16'hFFFF;
	localparam logic [WEIGHT_W-1:0] FILL_FRAC_RST = 16'h0001;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ENQ       = 2'd0,
		ACT_ENQ_FLUSH = 2'd1,
		ACT_DEQ       = 2'd2,
		ACT_NONE      = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK       = 2'd0,
		STS_BLOCK    = 2'd1,
		STS_EMPTY    = 2'd2,
		STS_BAD_SIZE = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAPACITY  = 8'd0,
		REG_FILL_FRAC = 8'd1
	} cfg_reg_t;

	// Divider status seen by the queue controller
	typedef struct packed {
		logic                busy;
		logic [WEIGHT_W-1:0] quot;
	} div_stat_t;

endpackage : wfw_pkg
`default_nettype wire

// ===== design/wfw_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfw_div
// Restoring divider, one quotient bit per cycle, for the watermark quotient.
// ----------------------------------------------------------------------------
module wfw_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire  [wfw_pkg::WEIGHT_W-1:0] dividend,
	input  wire  [wfw_pkg::WEIGHT_W-1:0] divisor,
	output wfw_pkg::div_stat_t           stat
);
	import wfw_pkg::*;

	logic [WEIGHT_W-1:0]  rem_q;
	logic [WEIGHT_W-1:0]  dvd_q;
	logic [WEIGHT_W-1:0]  dvs_q;
	logic [WEIGHT_W-1:0]  quot_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WEIGHT_W:0]    shifted;
	logic                 fits;
	logic [WEIGHT_W:0]    diff;

	assign shifted = {rem_q, dvd_q[WEIGHT_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			quot_q <= CAPACITY_RST;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(WEIGHT_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				quot_q <= {dvd_q[WEIGHT_W-2:0], fits};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			// zero divisor behaves as one
			dvs_q <= (divisor == '0) ? WEIGHT_W'(1) : divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[WEIGHT_W-1:0] : shifted[WEIGHT_W-1:0];
			dvd_q <= {dvd_q[WEIGHT_W-2:0], fits};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.quot = quot_q;

endmodule : wfw_div
`default_nettype wire

// ===== design/weighted_fifo_with_watermarks.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_fifo_with_watermarks
// Weighted FIFO with capacity admission and fill/drain wake flags.
// ----------------------------------------------------------------------------
// Each request passes two steps: the cycle it transfers in reads the head
// entry from the synchronous entry memories, the next cycle decides, writes
// the tail entry and loads the result register; a result not yet taken holds
// the decision step. Every request gives exactly one result. A configuration
// write is accepted only while no request is being decided. It recomputes the
// watermark quotient, capacity over the fill divisor, in a bit-serial divider:
// requests are held off after the write until the divider is done.
// There is no clearing pass after reset. On s_tdata the payload sits in the
// low bits followed by the entry weight; s_tuser carries the action code.
// ----------------------------------------------------------------------------
module weighted_fifo_with_watermarks #(
	parameter int ENTRY_DEPTH   = 64,
	parameter int PAYLOAD_WIDTH = 32,
	localparam int S_DATA_W = ((PAYLOAD_WIDTH + 16 + 7) / 8) * 8,
	localparam int M_DATA_W = ((PAYLOAD_WIDTH + 16 + 16 + 4 + 7) / 8) * 8
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// configuration
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [wfw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [wfw_pkg::WEIGHT_W-1:0]  cfg_data,
	// request stream
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [S_DATA_W-1:0]           s_tdata,  // payload, weight, zero fill
	input  wire  [wfw_pkg::ACTION_W-1:0]  s_tuser,  // action
	// result stream
	output logic                          m_tvalid,
	input  wire                           m_tready,
	// head_payload, head_size, used_weight, wake_consumer, wake_all_consumers,
	// wake_producer, is_empty, zero fill
	output logic [M_DATA_W-1:0]           m_tdata,
	output logic [wfw_pkg::STATUS_W-1:0]  m_tuser   // status
);
	import wfw_pkg::*;

	localparam int IDX_W = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
	localparam int CNT_W = $clog2(ENTRY_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [WEIGHT_W-1:0] capacity_q;
	logic [WEIGHT_W-1:0] fill_frac_q;
	logic                div_pend_q;
	div_stat_t           div_stat;

	logic [PAYLOAD_WIDTH-1:0] payload_mem [ENTRY_DEPTH];
	logic [WEIGHT_W-1:0]      size_mem    [ENTRY_DEPTH];
	logic [PAYLOAD_WIDTH-1:0] rd_payload_q;
	logic [WEIGHT_W-1:0]      rd_size_q;

	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [WEIGHT_W-1:0] used_q;

	action_t                  action_s1;
	logic [PAYLOAD_WIDTH-1:0] payload_s1;
	logic [WEIGHT_W-1:0]      size_s1;

	logic                     in_xfer;
	logic                     cfg_xfer;
	logic                     load_out;
	logic                     is_enq;
	logic                     bad_size;
	logic [WEIGHT_W:0]        enq_sum;
	logic                     enq_block;
	logic                     enq_ok;
	logic                     deq_ok;
	status_t                  status;
	logic [WEIGHT_W-1:0]      used_nxt;
	logic [PAYLOAD_WIDTH-1:0] head_payload;
	logic [WEIGHT_W-1:0]      head_size;
	logic                     wake_c;
	logic                     wake_a;
	logic                     wake_p;

	// configuration registers; requests are held while the quotient is stale
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_xfer  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAPACITY_RST;
			fill_frac_q <= FILL_FRAC_RST;
			div_pend_q  <= 1'b0;
		end else begin
			div_pend_q <= cfg_xfer;
			if (cfg_xfer) begin
				unique case (cfg_index)
					REG_CAPACITY:  capacity_q  <= cfg_data;
					REG_FILL_FRAC: fill_frac_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	wfw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_pend_q),
		.dividend (capacity_q),
		.divisor  (fill_frac_q),
		.stat     (div_stat)
	);

	assign s_tready = (state_q == ST_IDLE) && !div_pend_q && !div_stat.busy && !cfg_valid;
	assign in_xfer  = s_tvalid && s_tready;
	assign load_out = (state_q == ST_EXEC) && (!m_tvalid || m_tready);

	// request capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_s1  <= action_t'(s_tuser);
			payload_s1 <= s_tdata[PAYLOAD_WIDTH-1:0];
			size_s1    <= s_tdata[PAYLOAD_WIDTH +: WEIGHT_W];
		end
	end

	// entry memories: head read on transfer, tail write on admitted enqueue
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rd_payload_q <= payload_mem[head_q];
			rd_size_q    <= size_mem[head_q];
		end
		if (load_out && enq_ok) begin
			payload_mem[tail_q] <= payload_s1;
			size_mem[tail_q]    <= size_s1;
		end
	end

	// decision
	always_comb begin
		is_enq    = (action_s1 == ACT_ENQ) || (action_s1 == ACT_ENQ_FLUSH);
		bad_size  = (size_s1 == '0) || (size_s1 > capacity_q);
		enq_sum   = {1'b0, used_q} + {1'b0, size_s1};
		enq_block = (count_q >= CNT_W'(ENTRY_DEPTH)) || (enq_sum > {1'b0, capacity_q});
		enq_ok    = is_enq && !bad_size && !enq_block;
		deq_ok    = (action_s1 == ACT_DEQ) && (count_q != '0);

		status       = STS_OK;
		used_nxt     = used_q;
		head_payload = '0;
		head_size    = '0;
		wake_c       = 1'b0;
		wake_a       = 1'b0;
		wake_p       = 1'b0;

		unique case (action_s1)
			ACT_ENQ, ACT_ENQ_FLUSH: begin
				if (bad_size) begin
					status = STS_BAD_SIZE;
				end else if (enq_block) begin
					status = STS_BLOCK;
				end else begin
					used_nxt = enq_sum[WEIGHT_W-1:0];
					wake_c   = (enq_sum[WEIGHT_W-1:0] >= div_stat.quot);
					wake_a   = (action_s1 == ACT_ENQ_FLUSH);
				end
			end
			ACT_DEQ: begin
				if (!deq_ok) begin
					status = STS_EMPTY;
				end else begin
					head_payload = rd_payload_q;
					head_size    = rd_size_q;
					used_nxt     = (rd_size_q <= used_q) ? used_q - rd_size_q : '0;
					wake_p       = (used_nxt <= capacity_q - div_stat.quot);
				end
			end
			default: ;
		endcase
	end

	// queue state and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			used_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (load_out) begin
						state_q <= ST_IDLE;
						used_q  <= used_nxt;
						if (enq_ok) begin
							tail_q  <= (tail_q == IDX_W'(ENTRY_DEPTH - 1)) ? '0 : tail_q + 1'b1;
							count_q <= count_q + 1'b1;
						end else if (deq_ok) begin
							head_q  <= (head_q == IDX_W'(ENTRY_DEPTH - 1)) ? '0 : head_q + 1'b1;
							count_q <= count_q - 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_out) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tuser <= status;
			m_tdata <= M_DATA_W'({(used_nxt == '0), wake_p, wake_a, wake_c,
				used_nxt, head_size, head_payload});
		end
	end

endmodule : weighted_fifo_with_watermarks
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weighted FIFO with watermarks. A mirror of the
// queue predicts one result per request transfer; results are compared field
// by field in order. Covers directed corner cases, then random traffic over
// several capacity and fill fraction settings with stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

	import wfw_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int DEPTH        = 64;
	localparam int PAYLOAD_W    = 32;
	localparam int S_DATA_W     = 48;
	localparam int M_DATA_W     = 72;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 150;
	localparam int TAIL_CYCLES  = 20;

	typedef struct {
		status_t               status;
		logic [PAYLOAD_W-1:0]  head_payload;
		logic [WEIGHT_W-1:0]   head_size;
		logic [WEIGHT_W-1:0]   used_weight;
		logic                  wake_consumer;
		logic                  wake_all_consumers;
		logic                  wake_producer;
		logic                  is_empty;
	} queue_result_t;

	// Mirror of the queue contents, the registers and the results still owed
	class weight_queue_mirror;
		logic [PAYLOAD_W-1:0] payload_mem [DEPTH];
		logic [WEIGHT_W-1:0]  size_mem [DEPTH];
		int                   head_ptr;
		int                   tail_ptr;
		int                   entries;
		logic [WEIGHT_W-1:0]  used_sum;
		logic [WEIGHT_W-1:0]  capacity;
		logic [WEIGHT_W-1:0]  fill_frac;
		queue_result_t        awaited_results [$];
		int                   mismatches;

		function new();
			head_ptr   = 0;
			tail_ptr   = 0;
			entries    = 0;
			used_sum   = '0;
			capacity   = CAPACITY_RST;
			fill_frac  = FILL_FRAC_RST;
			mismatches = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [WEIGHT_W-1:0] value);
			case (idx)
				REG_CAPACITY:  capacity = value;
				REG_FILL_FRAC: fill_frac = value;
				default: ;
			endcase
		endfunction

		function int outstanding();
			return awaited_results.size();
		endfunction

		function void note_request(action_t act, logic [PAYLOAD_W-1:0] pl,
				logic [WEIGHT_W-1:0] sz);
			queue_result_t       r;
			logic [WEIGHT_W-1:0] mark;
			logic [WEIGHT_W:0]   grown;
			// a zero divisor counts as one
			mark = capacity / ((fill_frac == '0) ? 16'd1 : fill_frac);
			grown = used_sum + sz;
			r.status             = STS_OK;
			r.head_payload       = '0;
			r.head_size          = '0;
			r.wake_consumer      = 1'b0;
			r.wake_all_consumers = 1'b0;
			r.wake_producer      = 1'b0;
			case (act)
				ACT_ENQ, ACT_ENQ_FLUSH: begin
					if (sz == '0 || sz > capacity) begin
						r.status = STS_BAD_SIZE;
					end else if (entries >= DEPTH || grown > capacity) begin
						r.status = STS_BLOCK;
					end else begin
						payload_mem[tail_ptr] = pl;
						size_mem[tail_ptr]    = sz;
						tail_ptr = (tail_ptr == DEPTH - 1) ? 0 : tail_ptr + 1;
						entries++;
						used_sum = grown[WEIGHT_W-1:0];
						r.wake_consumer      = (used_sum >= mark);
						r.wake_all_consumers = (act == ACT_ENQ_FLUSH);
					end
				end
				ACT_DEQ: begin
					if (entries == 0) begin
						r.status = STS_EMPTY;
					end else begin
						r.head_payload = payload_mem[head_ptr];
						r.head_size    = size_mem[head_ptr];
						head_ptr = (head_ptr == DEPTH - 1) ? 0 : head_ptr + 1;
						entries--;
						used_sum = (r.head_size <= used_sum) ? used_sum - r.head_size : '0;
						r.wake_producer = (used_sum <= capacity - mark);
					end
				end
				ACT_NONE: ;
				default: ;
			endcase
			r.used_weight = used_sum;
			r.is_empty    = (used_sum == '0);
			awaited_results.push_back(r);
		endfunction

		function void compare_field(string field, logic [PAYLOAD_W-1:0] want,
				logic [PAYLOAD_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [M_DATA_W-1:0] data);
			queue_result_t r;
			if (awaited_results.size() == 0) begin
				$error("result transfer with no request outstanding");
				mismatches++;
				return;
			end
			r = awaited_results.pop_front();
			compare_field("status", r.status, st);
			compare_field("head_payload", r.head_payload, data[31:0]);
			compare_field("head_size", r.head_size, data[47:32]);
			compare_field("used_weight", r.used_weight, data[63:48]);
			compare_field("wake_consumer", r.wake_consumer, data[64]);
			compare_field("wake_all_consumers", r.wake_all_consumers, data[65]);
			compare_field("wake_producer", r.wake_producer, data[66]);
			compare_field("is_empty", r.is_empty, data[67]);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_CAPACITY;
	logic [WEIGHT_W-1:0]   cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata = '0;     // payload, weight
	logic [ACTION_W-1:0]   s_tuser = ACT_NONE; // action
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// head_payload, head_size, used_weight, wake_consumer, wake_all_consumers,
	// wake_producer, is_empty, zero fill
	logic [M_DATA_W-1:0]   m_tdata;
	logic [STATUS_W-1:0]   m_tuser;          // status

	int  send_idle_pct = 30;
	int  recv_idle_pct = 48;
	bit  hold_results = 1'b0;

	weight_queue_mirror tracker = new();

	weighted_fifo_with_watermarks #(
		.ENTRY_DEPTH   (DEPTH),
		.PAYLOAD_WIDTH (PAYLOAD_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic push_request(action_t act, logic [PAYLOAD_W-1:0] pl,
			logic [WEIGHT_W-1:0] sz);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {sz, pl};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
		tracker.note_request(act, pl, sz);
	endtask

	// deassert the request valid before waiting for the results to drain
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(cfg_reg_t idx, logic [WEIGHT_W-1:0] value);
		@(negedge clk);
		s_tvalid  <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_register(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_request(int enq_pct, int size_div);
		int                   pick;
		int                   span;
		action_t              act;
		logic [WEIGHT_W-1:0]  sz;
		span = tracker.capacity / size_div;
		if (span < 1)
			span = 1;
		pick = $urandom_range(99);
		if (pick < 4)
			act = ACT_NONE;
		else if (pick < 4 + enq_pct)
			act = ($urandom_range(3) == 0) ? ACT_ENQ_FLUSH : ACT_ENQ;
		else
			act = ACT_DEQ;
		pick = $urandom_range(99);
		if (pick < 3)
			sz = '0;
		else if (pick < 6)
			sz = WEIGHT_W'($urandom);
		else if (pick < 10)
			sz = tracker.capacity;
		else
			sz = WEIGHT_W'($urandom_range(span, 1));
		push_request(act, $urandom, sz);
	endtask

	// Reprogram while idle, optionally fill slots with small items, then mix
	task automatic run_setting(logic [WEIGHT_W-1:0] cap, logic [WEIGHT_W-1:0] frac,
			int size_div, int burst, int count);
		wait_drained();
		write_register(REG_CAPACITY, cap);
		write_register(REG_FILL_FRAC, frac);
		for (int n = 0; n < burst; n++)
			push_request(($urandom_range(1) != 0) ? ACT_ENQ_FLUSH : ACT_ENQ, $urandom,
				WEIGHT_W'($urandom_range(16, 1)));
		for (int n = 0; n < count; n++)
			random_request(((n / 30) % 2 == 0) ? 80 : 20, size_div);
	endtask

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				tracker.check_result(m_tuser, m_tdata);
			@(negedge clk);
			if (hold_results) begin
				hold_left    = HOLD_CYCLES;
				hold_results = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top failed");
		$finish;
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: full capacity, quotient equals capacity
		push_request(ACT_DEQ, 32'h1234_5678, 16'd7);
		push_request(ACT_ENQ, 32'h0000_0001, 16'd0);
		push_request(ACT_NONE, 32'hDEAD_BEEF, 16'd5);
		push_request(ACT_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
		push_request(ACT_ENQ, 32'h5555_5555, 16'd1);
		push_request(ACT_ENQ_FLUSH, 32'h0000_0000, 16'd1);
		push_request(ACT_DEQ, 32'h0, 16'd0);

		// zero fill fraction acts as one
		wait_drained();
		write_register(REG_CAPACITY, 16'd100);
		write_register(REG_FILL_FRAC, 16'd0);
		push_request(ACT_ENQ_FLUSH, 32'hAAAA_AAAA, 16'd101);
		push_request(ACT_ENQ_FLUSH, 32'hA5A5_A5A5, 16'd60);
		push_request(ACT_ENQ, 32'h5A5A_5A5A, 16'd40);
		push_request(ACT_ENQ_FLUSH, 32'h0F0F_0F0F, 16'd1);

		// capacity dropped below the held weight
		wait_drained();
		write_register(REG_CAPACITY, 16'd50);
		push_request(ACT_ENQ, 32'h3333_3333, 16'd10);
		push_request(ACT_ENQ, 32'hCCCC_CCCC, 16'd51);
		push_request(ACT_DEQ, 32'h0, 16'd0);
		push_request(ACT_DEQ, 32'h0, 16'd0);
		push_request(ACT_DEQ, 32'h0, 16'd0);

		run_setting(16'hFFFF, 16'd1, 200, 70, 150);
		run_setting(16'd1000, 16'd4, 12, 0, 150);
		send_idle_pct = 48;
		recv_idle_pct = 30;
		run_setting(16'd1, 16'hFFFF, 1, 0, 150);
		run_setting(16'd300, 16'd3, 8, 0, 150);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// starve the result side so requests back up into the input
		hold_results = 1'b1;
		run_setting(16'hFFFF, 16'hFFFF, 12, 0, 150);
		run_setting(16'd4096, 16'd7, 40, 0, 150);

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
